// ===== rtl/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

    // Width of every configuration register and of the configuration data port.
    localparam int CFG_WIDTH = 10;
    localparam int CFG_IDX_WIDTH = 3;

    // Window margins around each expected period: below and above.
    localparam int W50_BELOW = 2;
    localparam int W50_ABOVE = 1;
    localparam int W40_BELOW = 1;
    localparam int W40_ABOVE = 2;
    localparam int W30_BELOW = 3;
    localparam int W30_ABOVE = 3;
    localparam int W20_BELOW = 5;
    localparam int W20_ABOVE = 5;
    localparam int W10_BELOW = 10;
    localparam int W10_ABOVE = 10;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_50HZ = 10'd20;
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_40HZ = 10'd25;
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_30HZ = 10'd33;
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_20HZ = 10'd50;
    localparam logic [CFG_WIDTH-1:0] RST_PERIOD_10HZ = 10'd100;
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT = 10'd250;

    // Frequency classes as reported on the result channel.
    typedef enum logic [2:0] {
        CLS_0HZ  = 3'd0,
        CLS_10HZ = 3'd1,
        CLS_20HZ = 3'd2,
        CLS_30HZ = 3'd3,
        CLS_40HZ = 3'd4,
        CLS_50HZ = 3'd5
    } t_freq_class;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PERIOD_50HZ = 3'd0,
        REG_PERIOD_40HZ = 3'd1,
        REG_PERIOD_30HZ = 3'd2,
        REG_PERIOD_20HZ = 3'd3,
        REG_PERIOD_10HZ = 3'd4,
        REG_TIMEOUT     = 3'd5
    } t_cfg_idx;

    // The full set of configuration registers.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] period_50hz;
        logic [CFG_WIDTH-1:0] period_40hz;
        logic [CFG_WIDTH-1:0] period_30hz;
        logic [CFG_WIDTH-1:0] period_20hz;
        logic [CFG_WIDTH-1:0] period_10hz;
        logic [CFG_WIDTH-1:0] timeout_ticks;
    } t_cfg;

    // Outcome of the window tests for one measured period.
    typedef struct packed {
        logic        hit;
        t_freq_class cls;
    } t_match;

endpackage

`default_nettype wire

// ===== rtl/pfc_classify.sv =====
`default_nettype none

module pfc_classify
    import pfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire t_cfg                   i_cfg,
    output t_match                      o_match
);

    // Signed working width: wide enough for the count, a period and a margin.
    localparam int BASE_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int W = BASE_W + 2;

    logic signed [W-1:0] s_count;
    logic signed [W-1:0] s_p50, s_p40, s_p30, s_p20, s_p10;
    logic hit50, hit40, hit30, hit20, hit10;

    assign s_count = $signed(W'(i_count));
    assign s_p50 = $signed(W'(i_cfg.period_50hz));
    assign s_p40 = $signed(W'(i_cfg.period_40hz));
    assign s_p30 = $signed(W'(i_cfg.period_30hz));
    assign s_p20 = $signed(W'(i_cfg.period_20hz));
    assign s_p10 = $signed(W'(i_cfg.period_10hz));

    // Each window is inclusive; a negative lower bound admits every count.
    assign hit50 = (s_count >= s_p50 - $signed(W'(W50_BELOW)))
                && (s_count <= s_p50 + $signed(W'(W50_ABOVE)));
    assign hit40 = (s_count >= s_p40 - $signed(W'(W40_BELOW)))
                && (s_count <= s_p40 + $signed(W'(W40_ABOVE)));
    assign hit30 = (s_count >= s_p30 - $signed(W'(W30_BELOW)))
                && (s_count <= s_p30 + $signed(W'(W30_ABOVE)));
    assign hit20 = (s_count >= s_p20 - $signed(W'(W20_BELOW)))
                && (s_count <= s_p20 + $signed(W'(W20_ABOVE)));
    assign hit10 = (s_count >= s_p10 - $signed(W'(W10_BELOW)))
                && (s_count <= s_p10 + $signed(W'(W10_ABOVE)));

    // The highest frequency whose window matches wins.
    always_comb begin
        o_match.hit = 1'b1;
        o_match.cls = CLS_0HZ;
        priority if (hit50) begin
            o_match.cls = CLS_50HZ;
        end else if (hit40) begin
            o_match.cls = CLS_40HZ;
        end else if (hit30) begin
            o_match.cls = CLS_30HZ;
        end else if (hit20) begin
            o_match.cls = CLS_20HZ;
        end else if (hit10) begin
            o_match.cls = CLS_10HZ;
        end else begin
            o_match.hit = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfc_track.sv =====
`default_nettype none

module pfc_track
    import pfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_pin,
    input  wire t_cfg i_cfg,
    output t_freq_class o_class_next
);

    localparam int BASE_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_edge;
    logic                   r_prev;
    t_freq_class            r_class, n_class;
    t_freq_class            class_edge;
    logic                   rise;
    t_match                 match;

    // Saturating tick counter.
    assign count_inc = (&r_count) ? r_count : r_count + COUNT_WIDTH'(1);
    assign rise = i_pin & ~r_prev;

    pfc_classify #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_classify (
        .i_count(count_inc),
        .i_cfg  (i_cfg),
        .o_match(match)
    );

    // A rising edge classifies the period and restarts the count; then the
    // timeout test may force the class back to zero frequency.
    always_comb begin
        count_edge = count_inc;
        class_edge = r_class;
        if (rise) begin
            count_edge = '0;
            if (match.hit) begin
                class_edge = match.cls;
            end
        end
        n_count = count_edge;
        n_class = class_edge;
        if (BASE_W'(count_edge) >= BASE_W'(i_cfg.timeout_ticks)) begin
            n_count = '0;
            n_class = CLS_0HZ;
        end
    end

    assign o_class_next = n_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= 1'b0;
            r_class <= CLS_0HZ;
        end else if (i_step) begin
            r_count <= n_count;
            r_prev  <= i_pin;
            r_class <= n_class;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pulse_frequency_classifier.sv =====
`default_nettype none

// Pulse frequency classifier.
// Each input transaction is one sampling tick carrying the frequency pin and
// fault pin levels; each tick gives exactly one result transaction with the
// current frequency class (0, 10, 20, 30, 40 or 50 Hz) and the two pin levels.
// Both channels use valid and ready. A tick is first captured in an input
// register and is then classified and written to the result register once
// that register is free. One tick is accepted in every cycle while the
// receiver takes every result; the rate is set by the single counter and
// window-compare step between the two registers.
// When the receiver stalls, the result is held and one further tick may wait
// in the input register; input ready then drops until the result is taken.
// The configuration port writes one register per cycle when its enable is
// high; writes are expected only while the block is idle.
// A synchronous reset clears the counter, edge history and class to 0 Hz,
// restores the configuration defaults and empties both registers; no tick is
// accepted while reset is asserted.
module pulse_frequency_classifier
    import pfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_freq_pin,
    input  wire logic                     i_fault_pin,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [2:0]                    o_freq_class,
    output logic                          o_pin_level,
    output logic                          o_fault_flag,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [CFG_WIDTH-1:0]     i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic        r_s1_pin;
    logic        r_s1_fault;
    logic        r_out_valid;
    t_freq_class r_out_class;
    logic        r_out_pin;
    logic        r_out_fault;
    logic        out_free;
    logic        step;
    t_freq_class class_next;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_50hz   <= RST_PERIOD_50HZ;
            r_cfg.period_40hz   <= RST_PERIOD_40HZ;
            r_cfg.period_30hz   <= RST_PERIOD_30HZ;
            r_cfg.period_20hz   <= RST_PERIOD_20HZ;
            r_cfg.period_10hz   <= RST_PERIOD_10HZ;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_PERIOD_50HZ: r_cfg.period_50hz   <= i_cfg_data;
                REG_PERIOD_40HZ: r_cfg.period_40hz   <= i_cfg_data;
                REG_PERIOD_30HZ: r_cfg.period_30hz   <= i_cfg_data;
                REG_PERIOD_20HZ: r_cfg.period_20hz   <= i_cfg_data;
                REG_PERIOD_10HZ: r_cfg.period_10hz   <= i_cfg_data;
                REG_TIMEOUT:     r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result register frees when empty or being drained.
    assign out_free   = ~r_out_valid | i_out_ready;
    assign step       = r_s1_valid & out_free;
    assign o_in_ready = i_rst_n & (~r_s1_valid | out_free);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_pin   <= i_freq_pin;
            r_s1_fault <= i_fault_pin;
        end
    end

    pfc_track #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pin       (r_s1_pin),
        .i_cfg       (r_cfg),
        .o_class_next(class_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_class <= class_next;
            r_out_pin   <= r_s1_pin;
            r_out_fault <= r_s1_fault;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_freq_class = r_out_class;
    assign o_pin_level  = r_out_pin;
    assign o_fault_flag = r_out_fault;

endmodule

`default_nettype wire

// ===== rtl/pfc_checker.sv =====
`default_nettype none

module pfc_checker
    import pfc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] o_freq_class,
    input wire logic       o_pin_level,
    input wire logic       o_fault_flag
);

    // A delivered class is always one of the six frequency codes.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_freq_class <= CLS_50HZ))
        else $error("frequency class out of range");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_freq_class) && $stable(o_pin_level)
             && $stable(o_fault_flag)))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // No tick is taken while reset is held.
    a_reset_no_accept: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_in_ready)
        else $error("input ready during reset");

endmodule

bind pulse_frequency_classifier pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_freq_class(o_freq_class),
    .o_pin_level (o_pin_level),
    .o_fault_flag(o_fault_flag)
);

`default_nettype wire
